// File: src/framed_packet_receiver_crc8_assert.svh
// Assertion macros used by the framed packet receiver controller.
`ifndef FRAMED_PACKET_RECEIVER_CRC8_ASSERT_SVH
`define FRAMED_PACKET_RECEIVER_CRC8_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checks that a condition implies a consequence at the same clock edge.
`define FPRC8_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fprc8 assertion failed");

// Checks that a condition implies a consequence at the following clock edge.
`define FPRC8_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fprc8 assertion failed");

`else

`define FPRC8_ASSERT_SAME(label, clk, rst, ante, cons)
`define FPRC8_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: src/fprc8_pkg.sv
// Types, constants and the CRC-8 step function of the framed packet receiver.
`default_nettype none

package fprc8_pkg;

   localparam int BUFFER_BYTES_DEFAULT = 64;
   localparam int HEADER_BYTES         = 3;
   localparam int HEADER_AND_CHECK     = 4;
   localparam int BYTE_W               = 8;
   localparam int KIND_W               = 3;
   localparam int FRAME_LEN_W          = 6;
   localparam int BYTE_INDEX_W         = 6;
   localparam int LEN_CMP_W            = BYTE_W + 1;
   localparam int CSR_INDEX_W          = 2;

   localparam logic [BYTE_W-1:0] START_BYTE_RESET   = 8'hFF;
   localparam logic [BYTE_W-1:0] ACTION_LIMIT_RESET = 8'hFF;
   localparam logic [BYTE_W-1:0] CRC_POLY           = 8'h07;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_BYTE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTION_LIMIT = 2'd1;

   typedef enum logic [KIND_W-1:0] {
      KIND_PAYLOAD    = 3'd0,
      KIND_EMPTY      = 3'd1,
      KIND_BAD_ACTION = 3'd2,
      KIND_BAD_CRC    = 3'd3,
      KIND_BAD_LENGTH = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACTION,
      ST_LENGTH,
      ST_DATA,
      ST_PRIME,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_START,
      OP_ACTION,
      OP_LENGTH,
      OP_DATA
   } byte_op_type;

   typedef struct packed {
      byte_op_type op;
      logic        emit_start;
      logic        emit_prime;
      logic        emit_next;
      logic        out_load;
      kind_type    out_kind;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_start;
      logic action_bad;
      logic fill_full;
      logic frame_done;
      logic crc_ok;
      logic len_zero;
      logic emit_last;
   } dp_status_type;

   typedef struct packed {
      kind_type                 kind;
      logic [BYTE_W-1:0]        action;
      logic [FRAME_LEN_W-1:0]   frame_length;
      logic [BYTE_W-1:0]        payload_byte;
      logic [BYTE_INDEX_W-1:0]  byte_index;
      logic                     last;
   } rsp_payload_type;

   // One byte of CRC-8, polynomial 0x07, MSB first.
   function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int i = 0; i < BYTE_W; i++) begin
         c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: src/fprc8_req_if.sv
// Received byte channel.
`default_nettype none

interface fprc8_req_if import fprc8_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: src/fprc8_rsp_if.sv
// Result channel.
`default_nettype none

interface fprc8_rsp_if import fprc8_pkg::*; ;
   logic                    valid;
   logic                    ready;
   logic [KIND_W-1:0]       kind;
   logic [BYTE_W-1:0]       action;
   logic [FRAME_LEN_W-1:0]  frame_length;
   logic [BYTE_W-1:0]       payload_byte;
   logic [BYTE_INDEX_W-1:0] byte_index;
   logic                    last;

   modport source (output valid, output kind, output action, output frame_length,
                   output payload_byte, output byte_index, output last, input ready);
   modport sink   (input valid, input kind, input action, input frame_length,
                   input payload_byte, input byte_index, input last, output ready);
endinterface

`default_nettype wire

// File: src/fprc8_csr_if.sv
// Configuration register write channel.
`default_nettype none

interface fprc8_csr_if import fprc8_pkg::*; ;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [BYTE_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/fprc8_dpath.sv
// Datapath: configuration registers, frame state, CRC, payload store and result register.
`default_nettype none

module fprc8_dpath import fprc8_pkg::*; #(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   fprc8_csr_if.sink              csr,
   input  wire logic [BYTE_W-1:0] rx_byte,
   input  wire ctrl_cmd_type      cmd,
   output dp_status_type          status,
   output rsp_payload_type        rsp_payload
);

   localparam int STORE_DEPTH = BUFFER_BYTES - HEADER_AND_CHECK;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int FILL_W      = $clog2(BUFFER_BYTES + 1);

   logic [BYTE_W-1:0] start_byte_ff;
   logic [BYTE_W-1:0] action_limit_ff;

   logic [BYTE_W-1:0] crc_ff, crc_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [BYTE_W-1:0] action_ff, action_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   rsp_payload_type   out_ff, out_in;

   logic [BYTE_W-1:0] mem [STORE_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [FILL_W-1:0] wr_off;
   logic              mem_we;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;

   // Configuration registers take every transfer at once.
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff   <= START_BYTE_RESET;
         action_limit_ff <= ACTION_LIMIT_RESET;
      end else if (csr.valid && csr.ready) begin
         case (csr.index)
            CSR_START_BYTE:   start_byte_ff   <= csr.data;
            CSR_ACTION_LIMIT: action_limit_ff <= csr.data;
            default: ;
         endcase
      end
   end

   // Status decode of the byte on offer and of the frame state.
   always_comb begin
      status.is_start   = (rx_byte == start_byte_ff);
      status.action_bad = (rx_byte == '0) || (rx_byte >= action_limit_ff);
      status.fill_full  = (fill_ff >= FILL_W'(BUFFER_BYTES));
      status.frame_done = (LEN_CMP_W'(fill_ff) + LEN_CMP_W'(1)) ==
                          (LEN_CMP_W'(len_ff) + LEN_CMP_W'(HEADER_AND_CHECK));
      status.crc_ok     = (crc_ff == rx_byte);
      status.len_zero   = (len_ff == '0);
      status.emit_last  = (LEN_CMP_W'(idx_ff) + LEN_CMP_W'(1)) == LEN_CMP_W'(len_ff);
   end

   always_comb begin
      crc_in    = crc_ff;
      fill_in   = fill_ff;
      action_in = action_ff;
      len_in    = len_ff;
      case (cmd.op)
         OP_START: begin
            fill_in = FILL_W'(1);
            crc_in  = crc8_step('0, rx_byte);
         end
         OP_ACTION: begin
            action_in = rx_byte;
            fill_in   = FILL_W'(2);
            crc_in    = crc8_step(crc_ff, rx_byte);
         end
         OP_LENGTH: begin
            len_in  = rx_byte;
            fill_in = FILL_W'(HEADER_BYTES);
            crc_in  = crc8_step(crc_ff, rx_byte);
         end
         OP_DATA: begin
            fill_in = fill_ff + FILL_W'(1);
            crc_in  = crc8_step(crc_ff, rx_byte);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= '0;
         fill_ff   <= '0;
         action_ff <= '0;
         len_ff    <= '0;
      end else begin
         crc_ff    <= crc_in;
         fill_ff   <= fill_in;
         action_ff <= action_in;
         len_ff    <= len_in;
      end
   end

   // Payload bytes are stored by their position; the check byte lands behind them when the store has room.
   assign wr_off = fill_ff - FILL_W'(HEADER_BYTES);
   assign mem_we = (cmd.op == OP_DATA) && (wr_off < FILL_W'(STORE_DEPTH));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_off[ADDR_W-1:0]] <= rx_byte;
      end
   end

   // The read register holds the byte at idx_ff until the result register takes it.
   assign rd_en   = cmd.emit_prime || (cmd.emit_next && !status.emit_last);
   assign rd_addr = cmd.emit_next ? (idx_ff + ADDR_W'(1)) : idx_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.emit_start) begin
         idx_in = '0;
      end else if (cmd.emit_next) begin
         idx_in = idx_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   always_comb begin
      out_in              = out_ff;
      out_in.kind         = cmd.out_kind;
      out_in.action       = action_ff;
      out_in.frame_length = '0;
      out_in.payload_byte = '0;
      out_in.byte_index   = '0;
      out_in.last         = 1'b1;
      case (cmd.out_kind)
         KIND_PAYLOAD: begin
            out_in.frame_length = len_ff[FRAME_LEN_W-1:0];
            out_in.payload_byte = rd_data_ff;
            out_in.byte_index   = BYTE_INDEX_W'(idx_ff);
            out_in.last         = status.emit_last;
         end
         KIND_BAD_ACTION: out_in.action       = rx_byte;
         KIND_BAD_CRC:    out_in.frame_length = len_ff[FRAME_LEN_W-1:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_payload = out_ff;

endmodule

`default_nettype wire

// File: src/fprc8_ctrl.sv
// Controller: frame parsing state machine, input and result handshakes.
`default_nettype none

`include "framed_packet_receiver_crc8_assert.svh"

module fprc8_ctrl import fprc8_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   // The result register is free when empty or being emptied by this transfer.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (state_ff)
         ST_IDLE, ST_LENGTH: req_ready = 1'b1;
         ST_ACTION, ST_DATA: req_ready = out_free;
         default:            req_ready = 1'b0;
      endcase
   end

   assign accept = req_valid && req_ready;

   always_comb begin
      state_in       = state_ff;
      cmd.op         = OP_NONE;
      cmd.emit_start = 1'b0;
      cmd.emit_prime = 1'b0;
      cmd.emit_next  = 1'b0;
      cmd.out_load   = 1'b0;
      cmd.out_kind   = KIND_PAYLOAD;
      case (state_ff)
         ST_IDLE: begin
            if (accept && status.is_start) begin
               cmd.op   = OP_START;
               state_in = ST_ACTION;
            end
         end
         ST_ACTION: begin
            if (accept) begin
               if (status.action_bad) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = KIND_BAD_ACTION;
                  state_in     = ST_IDLE;
               end else begin
                  cmd.op   = OP_ACTION;
                  state_in = ST_LENGTH;
               end
            end
         end
         ST_LENGTH: begin
            if (accept) begin
               cmd.op   = OP_LENGTH;
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (accept) begin
               if (status.fill_full) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = KIND_BAD_LENGTH;
                  state_in     = ST_IDLE;
               end else begin
                  cmd.op = OP_DATA;
                  if (status.frame_done) begin
                     if (!status.crc_ok) begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_BAD_CRC;
                        state_in     = ST_IDLE;
                     end else if (status.len_zero) begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_EMPTY;
                        state_in     = ST_IDLE;
                     end else begin
                        cmd.emit_start = 1'b1;
                        state_in       = ST_PRIME;
                     end
                  end
               end
            end
         end
         ST_PRIME: begin
            cmd.emit_prime = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_kind  = KIND_PAYLOAD;
               cmd.emit_next = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `FPRC8_ASSERT_SAME(a_no_input_while_emitting, clock, reset, (state_ff == ST_PRIME) || (state_ff == ST_EMIT), !req_ready)
   `FPRC8_ASSERT_SAME(a_load_only_when_free, clock, reset, cmd.out_load, out_free)
   `FPRC8_ASSERT_NEXT(a_prime_then_emit, clock, reset, state_ff == ST_PRIME, (state_ff == ST_EMIT) && !rsp_valid_ff)
   `FPRC8_ASSERT_NEXT(a_last_payload_ends_frame, clock, reset, (state_ff == ST_EMIT) && cmd.out_load && status.emit_last, (state_ff == ST_IDLE) && rsp_valid_ff)

endmodule

`default_nettype wire

// File: src/framed_packet_receiver_crc8.sv
// Top level of the framed packet receiver with CRC-8 check.
// Usage:
//   req_chan carries one received byte per transfer. Frames are a start byte, an
//   action code, a length L, L payload bytes and a CRC-8 check byte (poly 0x07,
//   MSB first, init 0) over all bytes before it. Bytes other than the start
//   byte are dropped while no frame is open.
//   rsp_chan carries results: one per payload byte of a good frame (last on the
//   final one), or a single empty-frame or error result with last set.
//   csr_chan writes start_byte (index 0) and action_limit (index 1); it is always
//   ready, and other indexes are ignored.
// Timing:
//   While a frame is parsed, one byte is taken every cycle. A single result is in
//   the result register the cycle after the transfer that caused it. A good frame
//   with L payload bytes then holds req_chan off while ST_PRIME reads the first
//   byte from the payload memory and ST_EMIT gives one result per cycle through
//   the single read port of that memory, unless rsp_chan stalls.
//   If the receiver stalls rsp_chan, the payload stream waits, and action, data
//   and check bytes are not taken until the pending result has been transferred.
// Reset clears the parser and sets both registers to 0xFF; the payload memory is
// not cleared and needs no clearing pass.
`default_nettype none

module framed_packet_receiver_crc8 import fprc8_pkg::*; #(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   fprc8_req_if.sink    req_chan,
   fprc8_rsp_if.source  rsp_chan,
   fprc8_csr_if.sink    csr_chan
);

   ctrl_cmd_type    cmd;
   dp_status_type   status;
   rsp_payload_type rsp_payload;
   logic            ctrl_req_ready;
   logic            ctrl_rsp_valid;

   fprc8_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ctrl_req_ready),
      .rsp_valid (ctrl_rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   fprc8_dpath #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr_chan),
      .rx_byte     (req_chan.rx_byte),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   assign req_chan.ready        = ctrl_req_ready;
   assign rsp_chan.valid        = ctrl_rsp_valid;
   assign rsp_chan.kind         = rsp_payload.kind;
   assign rsp_chan.action       = rsp_payload.action;
   assign rsp_chan.frame_length = rsp_payload.frame_length;
   assign rsp_chan.payload_byte = rsp_payload.payload_byte;
   assign rsp_chan.byte_index   = rsp_payload.byte_index;
   assign rsp_chan.last         = rsp_payload.last;

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the framed packet receiver: byte streams in, every result checked.
`timescale 1ns / 1ps

module testbench;
   import fprc8_pkg::*;

   localparam int BUFFER_BYTES = BUFFER_BYTES_DEFAULT;
   localparam int STORE_DEPTH  = BUFFER_BYTES - HEADER_AND_CHECK;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 16;
   localparam int MAX_REPORTS  = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_HI = 2'd3;

   typedef enum logic [1:0] {
      AWAIT_START,
      AWAIT_ACTION,
      AWAIT_LENGTH,
      IN_PAYLOAD
   } parse_phase_type;

   logic clock;
   logic reset;

   fprc8_req_if req_chan ();
   fprc8_rsp_if rsp_chan ();
   fprc8_csr_if csr_chan ();

   framed_packet_receiver_crc8 #(.BUFFER_BYTES(BUFFER_BYTES)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Stimulus side.
   logic [7:0]  rx_q[$];
   logic [7:0]  frame_body[$];
   int unsigned bytes_queued = 0;
   int unsigned noise_bytes = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   logic        req_fire = 1'b0;

   // Predicted parser state and register copies.
   logic [7:0]      start_byte_reg;
   logic [7:0]      action_limit_reg;
   parse_phase_type parse_phase;
   logic [7:0]      crc_acc;
   int unsigned     frame_fill;
   logic [7:0]      frame_action;
   logic [7:0]      frame_length;
   logic [7:0]      payload_mem [0:STORE_DEPTH-1];

   rsp_payload_type predicted_rsp_q[$];
   int unsigned bytes_taken = 0;
   int unsigned csr_writes_seen = 0;
   int unsigned results_checked = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned kind_seen [0:4] = '{0, 0, 0, 0, 0};

   // Bit-serial CRC-8, polynomial 0x07, most significant bit first.
   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] r;
      logic       fb;
      r = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[7] ^ data[i];
         r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return r;
   endfunction

   function automatic void predict_result(input kind_type kind, input logic [7:0] act,
                                          input logic [5:0] len, input logic [7:0] data,
                                          input logic [5:0] idx, input logic fin);
      rsp_payload_type r;
      r.kind         = kind;
      r.action       = act;
      r.frame_length = len;
      r.payload_byte = data;
      r.byte_index   = idx;
      r.last         = fin;
      predicted_rsp_q.push_back(r);
   endfunction

   function automatic void parse_rx_byte(input logic [7:0] b);
      case (parse_phase)
         AWAIT_START: begin
            if (b == start_byte_reg) begin
               frame_fill  = 1;
               crc_acc     = crc8_next(8'h00, b);
               parse_phase = AWAIT_ACTION;
            end
         end
         AWAIT_ACTION: begin
            if (b == 8'h00 || b >= action_limit_reg) begin
               parse_phase = AWAIT_START;
               predict_result(KIND_BAD_ACTION, b, 6'd0, 8'h00, 6'd0, 1'b1);
            end else begin
               frame_action = b;
               frame_fill   = 2;
               crc_acc      = crc8_next(crc_acc, b);
               parse_phase  = AWAIT_LENGTH;
            end
         end
         AWAIT_LENGTH: begin
            frame_length = b;
            frame_fill   = 3;
            crc_acc      = crc8_next(crc_acc, b);
            parse_phase  = IN_PAYLOAD;
         end
         default: begin
            if (frame_fill >= BUFFER_BYTES) begin
               parse_phase = AWAIT_START;
               predict_result(KIND_BAD_LENGTH, frame_action, 6'd0, 8'h00, 6'd0, 1'b1);
            end else begin
               // The check byte lands in the store too when there is room; it is never emitted.
               if (frame_fill - HEADER_BYTES < STORE_DEPTH)
                  payload_mem[frame_fill - HEADER_BYTES] = b;
               frame_fill++;
               if (frame_fill == HEADER_AND_CHECK + int'(frame_length)) begin
                  parse_phase = AWAIT_START;
                  if (crc_acc != b) begin
                     predict_result(KIND_BAD_CRC, frame_action, frame_length[5:0], 8'h00,
                                    6'd0, 1'b1);
                  end else if (frame_length == 8'd0) begin
                     predict_result(KIND_EMPTY, frame_action, 6'd0, 8'h00, 6'd0, 1'b1);
                  end else begin
                     for (int i = 0; i < int'(frame_length) && i < STORE_DEPTH; i++)
                        predict_result(KIND_PAYLOAD, frame_action, frame_length[5:0],
                                       payload_mem[i], 6'(i), i + 1 == int'(frame_length));
                  end
               end else begin
                  crc_acc = crc8_next(crc_acc, b);
               end
            end
         end
      endcase
   endfunction

   function automatic void check_result();
      rsp_payload_type want;
      if (predicted_rsp_q.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("Unexpected result at cycle %0d: kind %0d action %02h len %0d",
                     cycle_count, rsp_chan.kind, rsp_chan.action, rsp_chan.frame_length);
      end else begin
         want = predicted_rsp_q.pop_front();
         results_checked++;
         kind_seen[want.kind]++;
         if (rsp_chan.kind !== want.kind || rsp_chan.action !== want.action ||
             rsp_chan.frame_length !== want.frame_length ||
             rsp_chan.payload_byte !== want.payload_byte ||
             rsp_chan.byte_index !== want.byte_index || rsp_chan.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("Mismatch at cycle %0d:", cycle_count);
               $display("  expected kind %0d action %02h len %0d byte %02h idx %0d last %0b",
                        want.kind, want.action, want.frame_length, want.payload_byte,
                        want.byte_index, want.last);
               $display("  got      kind %0d action %02h len %0d byte %02h idx %0d last %0b",
                        rsp_chan.kind, rsp_chan.action, rsp_chan.frame_length,
                        rsp_chan.payload_byte, rsp_chan.byte_index, rsp_chan.last);
            end
         end
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Monitor: samples every transfer at the rising edge.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still expected", cycle_count,
                  predicted_rsp_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
      req_fire <= req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            parse_rx_byte(req_chan.rx_byte);
            bytes_taken++;
         end
         if (csr_chan.valid && csr_chan.ready) begin
            if (csr_chan.index == CSR_START_BYTE)
               start_byte_reg = csr_chan.data;
            else if (csr_chan.index == CSR_ACTION_LIMIT)
               action_limit_reg = csr_chan.data;
            csr_writes_seen++;
         end
         if (rsp_chan.valid && rsp_chan.ready)
            check_result();
      end
   end

   // Driver: presents queued bytes and the receiver's ready at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_fire) begin
         if (rx_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_chan.valid   <= 1'b1;
            req_chan.rx_byte <= rx_q.pop_front();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
      rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic void queue_byte(input logic [7:0] b);
      rx_q.push_back(b);
      bytes_queued++;
   endfunction

   // A byte other than the start byte, dropped while no frame is open.
   function automatic void queue_noise(input logic [7:0] sb);
      logic [7:0] b;
      b = 8'($urandom);
      if (b == sb)
         b = ~sb;
      queue_byte(b);
      noise_bytes++;
   endfunction

   function automatic void fill_body(input int unsigned len);
      frame_body.delete();
      repeat (len) frame_body.push_back(8'($urandom));
   endfunction

   // Sends a whole frame around frame_body; crc_xor nonzero spoils the check byte.
   function automatic void queue_frame(input logic [7:0] sb, input logic [7:0] act,
                                       input logic [7:0] crc_xor);
      logic [7:0] crc;
      logic [7:0] len;
      len = 8'(frame_body.size());
      crc = crc8_next(crc8_next(crc8_next(8'h00, sb), act), len);
      queue_byte(sb);
      queue_byte(act);
      queue_byte(len);
      foreach (frame_body[i]) begin
         crc = crc8_next(crc, frame_body[i]);
         queue_byte(frame_body[i]);
      end
      queue_byte(crc ^ crc_xor);
   endfunction

   // A length beyond the store: the byte after a full buffer draws the length error.
   function automatic void queue_overlong(input logic [7:0] sb, input logic [7:0] act,
                                          input logic [7:0] len);
      queue_byte(sb);
      queue_byte(act);
      queue_byte(len);
      repeat (BUFFER_BYTES - HEADER_BYTES + 1) queue_byte(8'($urandom));
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] value);
      int unsigned target;
      target = csr_writes_seen + 1;
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(negedge clock); while (csr_writes_seen != target);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic wait_quiet();
      do @(negedge clock);
      while (bytes_taken != bytes_queued || predicted_rsp_q.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Mostly well-formed frames with random content, plus broken ones and line noise.
   task automatic random_traffic(input logic [7:0] sb, input logic [7:0] lim,
                                 input int unsigned n);
      int unsigned goal;
      int unsigned pick;
      int unsigned size_pick;
      logic [7:0]  act;
      logic [7:0]  bad_act;
      goal = bytes_queued - noise_bytes + n;
      while (bytes_queued - noise_bytes < goal) begin
         pick      = $urandom_range(99);
         size_pick = $urandom_range(99);
         act       = (lim > 8'd1) ? 8'($urandom_range(int'(lim) - 1, 1)) : 8'($urandom);
         bad_act   = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255, int'(lim)));
         if (size_pick < 85)
            fill_body($urandom_range(4));
         else if (size_pick < 98)
            fill_body($urandom_range(20, 5));
         else
            fill_body(STORE_DEPTH);
         if (pick < 60) begin
            queue_frame(sb, act, 8'h00);
         end else if (pick < 70) begin
            queue_frame(sb, act, 8'($urandom_range(255, 1)));
         end else if (pick < 78) begin
            queue_byte(sb);
            queue_byte(bad_act);
         end else if (pick < 88) begin
            queue_noise(sb);
         end else if (pick < 97) begin
            // Cut short: the following bytes are taken as the rest of this frame.
            queue_byte(sb);
            queue_byte(act);
            repeat ($urandom_range(2)) queue_byte(8'($urandom));
         end else begin
            queue_overlong(sb, act, 8'($urandom_range(255, STORE_DEPTH + 1)));
         end
      end
   endtask

   task automatic run_phase(input logic [7:0] sb, input logic [7:0] lim,
                            input int unsigned idle_pct, input int unsigned stall_pct,
                            input int unsigned n);
      write_csr(CSR_START_BYTE, sb);
      write_csr(CSR_ACTION_LIMIT, lim);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      random_traffic(sb, lim, n);
      wait_quiet();
   endtask

   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = 8'h00;
      rsp_chan.ready   = 1'b0;
      csr_chan.valid   = 1'b0;
      csr_chan.index   = CSR_START_BYTE;
      csr_chan.data    = 8'h00;
      start_byte_reg   = START_BYTE_RESET;
      action_limit_reg = ACTION_LIMIT_RESET;
      parse_phase      = AWAIT_START;
      crc_acc          = 8'h00;
      frame_fill       = 0;
      frame_action     = 8'h00;
      frame_length     = 8'h00;
      foreach (payload_mem[i]) payload_mem[i] = 8'h00;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames under the reset register values, no idling.
      queue_noise(START_BYTE_RESET);
      queue_noise(START_BYTE_RESET);
      fill_body(0);
      queue_frame(START_BYTE_RESET, 8'h01, 8'h00);
      queue_byte(START_BYTE_RESET);
      queue_byte(8'h00);
      queue_byte(START_BYTE_RESET);
      queue_byte(ACTION_LIMIT_RESET);
      // Start byte and zero inside the payload, highest accepted action.
      frame_body = '{START_BYTE_RESET, 8'h00};
      queue_frame(START_BYTE_RESET, ACTION_LIMIT_RESET - 8'd1, 8'h00);
      fill_body(1);
      queue_frame(START_BYTE_RESET, 8'h01, 8'h5A);
      // Longest frame the store holds, then one byte too many.
      fill_body(STORE_DEPTH);
      queue_frame(START_BYTE_RESET, 8'h42, 8'h00);
      queue_overlong(START_BYTE_RESET, 8'h42, 8'(STORE_DEPTH + 1));
      random_traffic(START_BYTE_RESET, ACTION_LIMIT_RESET, 10);
      wait_quiet();

      run_phase(8'h00, 8'd1, 72, 0, 10);
      write_csr(CSR_UNUSED_LO, 8'h00);
      run_phase(8'h7E, 8'd16, 0, 72, 20);
      run_phase(8'hFF, 8'd255, 12, 12, 20);
      run_phase(8'h55, 8'd0, 0, 0, 5);
      write_csr(CSR_UNUSED_HI, 8'h01);
      run_phase(8'hC3, 8'd128, 72, 0, 15);
      run_phase(8'h3C, 8'd200, 0, 72, 15);

      $display(
         "Sent %0d bytes (%0d idle noise) under seven register settings, four idle patterns.",
         bytes_queued, noise_bytes);
      $display(
         "Checked %0d results: %0d payload, %0d empty, %0d bad action, %0d bad crc, %0d overlong.",
         results_checked, kind_seen[KIND_PAYLOAD], kind_seen[KIND_EMPTY],
         kind_seen[KIND_BAD_ACTION], kind_seen[KIND_BAD_CRC], kind_seen[KIND_BAD_LENGTH]);
      if (mismatches == 0 && predicted_rsp_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d results never arrived", mismatches,
                  predicted_rsp_q.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
